### rtl/rcvc_pkg.sv
// shared types and constants for the rtc calibration value calculator
// no dependencies; imported by every other file of the block
`default_nettype none

package rcvc_pkg;

    localparam int unsigned FACTOR_W = 19;
    localparam int unsigned MAG_W    = 31;
    localparam int unsigned SMAG_W   = 13;
    localparam int unsigned QUO_W    = 19;
    localparam int unsigned CNT_W    = 5;

    localparam logic [FACTOR_W-1:0] FAST_FACTOR = 19'd491520;
    localparam logic [FACTOR_W-1:0] SLOW_FACTOR = 19'd245760;
    localparam logic [MAG_W-1:0]    DEV_LIMIT   = 31'd4369;
    localparam logic [4:0]          CALIB_MAX   = 5'd31;
    localparam logic [CNT_W-1:0]    DIV_STEPS   = 5'd19;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PARAM  = 2'd1;
    localparam logic [1:0] ST_EXCESS = 2'd2;

    typedef struct packed {
        logic signed [31:0] duration_sec;
        logic signed [31:0] deviation_sec;
    } in_item_t;

    typedef struct packed {
        logic [5:0] calib_byte;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic check;
        logic scale;
        logic mult;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic param_err;
        logic mag_big;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/rcvc_dp.sv
// datapath: magnitude, range check, scaling, product and restoring divider
// depends on rcvc_pkg; driven by rcvc_ctrl through dp_cmd_t
`default_nettype none

module rcvc_dp
    import rcvc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_data,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output out_item_t      out_data
);

    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [MAG_W-1:0]  d_reg, d_next;
    logic              dnp_reg, dnp_next;
    logic              sign_reg, sign_next;
    logic              excess_reg, excess_next;
    logic              err_reg, err_next;
    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    out_item_t         out_reg, out_next;

    logic [31:0]          neg_dev;
    logic [MAG_W-1:0]     in_mag;
    logic [FACTOR_W-1:0]  factor;
    logic [31:0]          prod;
    logic [31:0]          trial;
    logic                 trial_ge;
    logic [31:0]          trial_sub;
    logic                 round_up;
    logic [QUO_W:0]       quo_rnd;
    logic                 sat;
    logic [4:0]           mag5;

    always_comb
    begin
        neg_dev = 32'(~in_data.deviation_sec) + 32'd1;
        if (!in_data.deviation_sec[31])
            in_mag = in_data.deviation_sec[30:0];
        else if (in_data.deviation_sec == 32'sh8000_0000)
            in_mag = '1;
        else
            in_mag = neg_dev[30:0];

        factor    = sign_reg ? SLOW_FACTOR : FAST_FACTOR;
        prod      = 32'(factor) * 32'(mag_reg[SMAG_W-1:0]);
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        trial_ge  = trial >= {1'b0, d_reg};
        trial_sub = trial - {1'b0, d_reg};
        round_up  = {rem_reg, 1'b0} >= {1'b0, d_reg};
        quo_rnd   = {1'b0, quo_reg} + (QUO_W+1)'(round_up);
        sat       = quo_rnd > (QUO_W+1)'(CALIB_MAX);
        mag5      = sat ? CALIB_MAX : quo_rnd[4:0];

        stat.param_err = dnp_reg || (mag_reg > d_reg);
        stat.mag_big   = mag_reg > DEV_LIMIT;

        mag_next    = mag_reg;
        d_next      = d_reg;
        dnp_next    = dnp_reg;
        sign_next   = sign_reg;
        excess_next = excess_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        out_next    = out_reg;

        if (cmd.load)
        begin
            mag_next    = in_mag;
            d_next      = in_data.duration_sec[30:0];
            dnp_next    = in_data.duration_sec[31] || (in_data.duration_sec == 32'sd0);
            sign_next   = in_data.deviation_sec[31];
            excess_next = 1'b0;
        end
        if (cmd.check)
            err_next = stat.param_err;
        if (cmd.scale)
        begin
            mag_next    = mag_reg >> 1;
            d_next      = d_reg >> 1;
            excess_next = 1'b1;
        end
        if (cmd.mult)
        begin
            rem_next = MAG_W'(prod[30:QUO_W]);
            quo_next = prod[QUO_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_next = trial_ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            if (err_reg)
            begin
                out_next.calib_byte = '0;
                out_next.status     = ST_PARAM;
            end
            else
            begin
                out_next.calib_byte = {sign_reg, mag5};
                out_next.status     = (excess_reg || sat) ? ST_EXCESS : ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        d_reg      <= d_next;
        dnp_reg    <= dnp_next;
        sign_reg   <= sign_next;
        excess_reg <= excess_next;
        err_reg    <= err_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        out_reg    <= out_next;
    end

    assign out_data = out_reg;

    // scaling leaves a narrow magnitude that the duration still covers
    a_scaled_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mult |-> (mag_reg <= DEV_LIMIT) && (d_reg >= mag_reg))
        else $error("scaled magnitude out of range");

    // partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < d_reg))
        else $error("divider remainder not below divisor");

    // no division by zero after a clean check
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mult || cmd.div_step) |-> (d_reg != '0) && !err_reg)
        else $error("divide started with zero divisor or parameter error");

endmodule

`default_nettype wire

### rtl/rcvc_ctrl.sv
// controller: sequences load, check, scaling, multiply, divide and output
// depends on rcvc_pkg; drives rcvc_dp through dp_cmd_t
`default_nettype none

module rcvc_ctrl
    import rcvc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire dp_stat_t  stat,
    output dp_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_MULT  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.param_err ? S_OUT : S_SCALE;
            end
            S_SCALE:
            begin
                if (stat.mag_big)
                    cmd.scale = 1'b1;
                else
                    state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                cnt_next   = DIV_STEPS;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while pending");

    // an accepted transaction goes straight to the range check
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted transaction not checked");

    // the divider runs its full step count before output
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == CNT_W'(1)) |=> (state_reg == S_OUT))
        else $error("divider did not finish into output");

    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("divider step count ran out");

endmodule

`default_nettype wire

### rtl/rtc_calibration_value_calc.sv
// rtc calibration value calculator: duration and signed drift in, calibration byte out
// depends on rcvc_pkg, rcvc_ctrl and rcvc_dp
//
// One transaction at a time: a transaction is accepted when the block is idle, a range
// check follows, then the halving state halves magnitude and duration as often as
// needed (0 to 19 halvings, set by how far the deviation magnitude exceeds 4369), the
// product is formed, a restoring divider forms the 19-bit quotient and the output
// register is loaded once any pending result has been taken; a parameter error goes
// from the check straight to the output load. The result register lets the next
// transaction be accepted while a result waits to be taken.
`default_nettype none

module rtc_calibration_value_calc
    import rcvc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rcvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rcvc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
